/* hdl/cascaded_prescaled_timers_unit_macros.svh */
// Assertion macros shared by the timer block.
`ifndef CASCADED_PRESCALED_TIMERS_UNIT_MACROS_SVH
`define CASCADED_PRESCALED_TIMERS_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CPT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define CPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/cpt_pkg.sv */
package cpt_pkg;

    localparam int NUM_TIMERS  = 4;
    localparam int IDX_W       = 2;
    localparam int DATA_W      = 16;
    localparam int CTRL_W      = 8;
    localparam int PRESCALE_W  = 11;
    localparam int FLAG_W      = 4;

    localparam int CTL_CASCADE = 2;
    localparam int CTL_IRQ     = 6;
    localparam int CTL_ENABLE  = 7;

    localparam logic [DATA_W-1:0] COUNT_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        REQ_TICK   = 2'd0,
        REQ_RELOAD = 2'd1,
        REQ_CTRL   = 2'd2,
        REQ_READ   = 2'd3
    } req_type_t;

    typedef struct packed {
        req_type_t          req_type;
        logic [IDX_W-1:0]   timer_index;
        logic [DATA_W-1:0]  write_data;
    } req_word_t;

    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        logic [FLAG_W-1:0]  overflow_flags;
        logic [FLAG_W-1:0]  irq_flags;
    } rsp_word_t;

    // Per-timer command strobes for one processed word.
    typedef struct packed {
        logic               tick;
        logic               wr_reload;
        logic               wr_ctrl;
        logic [DATA_W-1:0]  data;
    } timer_cmd_t;

    // Status a timer reports back to the top level.
    typedef struct packed {
        logic [DATA_W-1:0]  count;
        logic               ovf;
        logic               irq;
    } timer_status_t;

    function automatic logic [PRESCALE_W-1:0] prescale_amount(input logic [1:0] sel);
        logic [PRESCALE_W-1:0] amt;
        case (sel)
            2'd0:    amt = PRESCALE_W'(1);
            2'd1:    amt = PRESCALE_W'(64);
            2'd2:    amt = PRESCALE_W'(256);
            2'd3:    amt = PRESCALE_W'(1024);
            default: amt = PRESCALE_W'(1);
        endcase
        return amt;
    endfunction

endpackage

/* hdl/cascaded_prescaled_timers_unit.sv */
// Channel | Handshake               | Word
// --------+-------------------------+------------------------------------------
// req     | req_valid / req_stall   | req_word: req_type, timer_index, write_data
// rsp     | rsp_valid / rsp_stall   | rsp_word: read_data, overflow_flags, irq_flags
//
// One word per cycle sustained while rsp_stall is low. An input register feeds the timer
// update, which settles all four timers and the cascade chain combinationally into the
// result register, from which a word's result is valid.
// rsp_stall holds the result register and then the input register; req_stall rises
// only while both are full. Reset clears all timer state to zero.

`include "cascaded_prescaled_timers_unit_macros.svh"

module cascaded_prescaled_timers_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  cpt_pkg::req_word_t req_word,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output cpt_pkg::rsp_word_t rsp_word
);

    logic                 req_valid_reg, req_valid_next;
    cpt_pkg::req_word_t   req_word_reg;
    logic                 rsp_valid_reg, rsp_valid_next;
    cpt_pkg::rsp_word_t   rsp_word_reg, rsp_word_next;

    logic                 req_take;
    logic                 advance;
    logic [cpt_pkg::NUM_TIMERS-1:0] sel;
    logic [cpt_pkg::NUM_TIMERS-1:0] ovf;
    logic [cpt_pkg::NUM_TIMERS-1:0] irq;
    logic [cpt_pkg::NUM_TIMERS-1:0] chain;
    logic [cpt_pkg::FLAG_W-1:0]     ovf_flags;
    logic [cpt_pkg::FLAG_W-1:0]     irq_flags;
    logic [cpt_pkg::DATA_W-1:0]     rd_data;
    cpt_pkg::timer_cmd_t            cmd     [cpt_pkg::NUM_TIMERS];
    cpt_pkg::timer_status_t         status  [cpt_pkg::NUM_TIMERS];

    assign advance   = req_valid_reg && !(rsp_valid_reg && rsp_stall);
    assign req_stall = req_valid_reg && !advance;
    assign req_take  = req_valid && !req_stall;

    assign chain[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < cpt_pkg::NUM_TIMERS; g++)
        begin : g_timer
            assign sel[g] = (req_word_reg.timer_index == cpt_pkg::IDX_W'(g));

            assign cmd[g].tick      = advance && (req_word_reg.req_type == cpt_pkg::REQ_TICK);
            assign cmd[g].wr_reload = advance && sel[g]
                                      && (req_word_reg.req_type == cpt_pkg::REQ_RELOAD);
            assign cmd[g].wr_ctrl   = advance && sel[g]
                                      && (req_word_reg.req_type == cpt_pkg::REQ_CTRL);
            assign cmd[g].data      = req_word_reg.write_data;

            cpt_timer u_timer (
                .clk      (clk),
                .rst_n    (rst_n),
                .cmd      (cmd[g]),
                .first    (g == 0),
                .chain_in (chain[g]),
                .status   (status[g])
            );

            assign ovf[g] = status[g].ovf;
            assign irq[g] = status[g].irq;

            if (g + 1 < cpt_pkg::NUM_TIMERS)
            begin : g_chain
                assign chain[g + 1] = status[g].ovf;
            end
        end

        for (g = 0; g < cpt_pkg::FLAG_W; g++)
        begin : g_flag
            if (g < cpt_pkg::NUM_TIMERS)
            begin : g_live
                assign ovf_flags[g] = ovf[g];
                assign irq_flags[g] = irq[g];
            end
            else
            begin : g_none
                assign ovf_flags[g] = 1'b0;
                assign irq_flags[g] = 1'b0;
            end
        end
    endgenerate

    always_comb
    begin
        rd_data = '0;
        for (int i = 0; i < cpt_pkg::NUM_TIMERS; i++)
        begin
            if (sel[i])
            begin
                rd_data = status[i].count;
            end
        end

        rsp_word_next = '0;
        case (req_word_reg.req_type)
            cpt_pkg::REQ_TICK:
            begin
                rsp_word_next.overflow_flags = ovf_flags;
                rsp_word_next.irq_flags      = irq_flags;
            end
            cpt_pkg::REQ_READ:
            begin
                rsp_word_next.read_data = rd_data;
            end
            default:
            begin
                rsp_word_next = '0;
            end
        endcase

        if (req_take)
        begin
            req_valid_next = 1'b1;
        end
        else if (advance)
        begin
            req_valid_next = 1'b0;
        end
        else
        begin
            req_valid_next = req_valid_reg;
        end

        if (advance)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers: load only on a move
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            req_word_reg <= req_word;
        end
        if (advance)
        begin
            rsp_word_reg <= rsp_word_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    `CPT_ASSERT_NOW(a_irq_needs_ovf, rsp_valid_reg,
        (rsp_word_reg.irq_flags & ~rsp_word_reg.overflow_flags) == '0,
        "interrupt flag without overflow")
    `CPT_ASSERT_NOW(a_read_no_flags, rsp_valid_reg && (rsp_word_reg.read_data != '0),
        (rsp_word_reg.overflow_flags == '0) && (rsp_word_reg.irq_flags == '0),
        "read result carries flags")
    `CPT_ASSERT_NEXT(a_advance_fills, advance, rsp_valid_reg,
        "processed word lost before result register")
    `CPT_ASSERT_NEXT(a_hold_on_stall, req_valid_reg && rsp_valid_reg && rsp_stall,
        req_valid_reg && rsp_valid_reg,
        "word dropped while result stalled")

endmodule

/* hdl/cpt_timer.sv */
module cpt_timer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cpt_pkg::timer_cmd_t  cmd,
    input  logic                 first,
    input  logic                 chain_in,
    output cpt_pkg::timer_status_t status
);

    logic [cpt_pkg::DATA_W-1:0]     count_reg, count_next;
    logic [cpt_pkg::DATA_W-1:0]     reload_reg, reload_next;
    logic [cpt_pkg::CTRL_W-1:0]     ctrl_reg, ctrl_next;
    logic [cpt_pkg::PRESCALE_W-1:0] prescale_reg, prescale_next;
    logic                           enable_reg, enable_next;

    logic [cpt_pkg::DATA_W-1:0]     count_loaded;
    logic [cpt_pkg::PRESCALE_W-1:0] amt;
    logic [cpt_pkg::PRESCALE_W-1:0] prescale_left;
    logic                           enabled;
    logic                           chained;
    logic                           step;
    logic                           ovf;

    always_comb
    begin
        enabled       = ctrl_reg[cpt_pkg::CTL_ENABLE];
        chained       = ctrl_reg[cpt_pkg::CTL_CASCADE] && !first;
        amt           = cpt_pkg::prescale_amount(ctrl_reg[1:0]);
        // load from reload value on a rising edge of enable
        count_loaded  = (!enable_reg && enabled) ? reload_reg : count_reg;
        prescale_left = prescale_reg;
        step          = 1'b0;
        ovf           = 1'b0;

        count_next    = count_reg;
        prescale_next = prescale_reg;
        enable_next   = enable_reg;
        reload_next   = reload_reg;
        ctrl_next     = ctrl_reg;

        if (cmd.tick)
        begin
            enable_next = enabled;
            count_next  = count_loaded;
            if (enabled)
            begin
                if (chained)
                begin
                    step = chain_in;
                end
                else if (prescale_reg >= amt)
                begin
                    step          = 1'b1;
                    prescale_left = prescale_reg - amt;
                end
                if (step)
                begin
                    if (count_loaded == cpt_pkg::COUNT_MAX)
                    begin
                        ovf        = 1'b1;
                        count_next = reload_reg;
                    end
                    else
                    begin
                        count_next = count_loaded + cpt_pkg::DATA_W'(1);
                    end
                end
                prescale_next = prescale_left + cpt_pkg::PRESCALE_W'(1);
            end
        end

        if (cmd.wr_reload)
        begin
            reload_next = cmd.data;
        end
        if (cmd.wr_ctrl)
        begin
            ctrl_next = cmd.data[cpt_pkg::CTRL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            reload_reg   <= '0;
            ctrl_reg     <= '0;
            prescale_reg <= '0;
            enable_reg   <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            reload_reg   <= reload_next;
            ctrl_reg     <= ctrl_next;
            prescale_reg <= prescale_next;
            enable_reg   <= enable_next;
        end
    end

    assign status.count = count_reg;
    assign status.ovf   = ovf;
    assign status.irq   = ovf && ctrl_reg[cpt_pkg::CTL_IRQ];

endmodule
